FILE: hw/rtl/mfbfs_pkg.sv
// package for the bfs augmenting-path max flow engine
// sequencer states, sizes and field widths; no dependencies
package mfbfs_pkg;

  localparam int MaxVertices = 64;
  localparam int VtxBits     = $clog2(MaxVertices);
  localparam int AddrBits    = 2 * VtxBits;
  localparam int CapBits     = 31;
  localparam int ResBits     = CapBits + 1;
  localparam int FlowBits    = 64;
  localparam int CntBits     = 7;
  localparam int IdxBits     = VtxBits + 1;

  localparam logic KindLoad = 1'b0;
  localparam logic KindRun  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COPY_RD,
    ST_COPY_WR,
    ST_BFS_INIT,
    ST_BFS_POP,
    ST_BFS_SCAN,
    ST_BFS_CHECK,
    ST_BN_RD,
    ST_BN_CMP,
    ST_UP_FWD_RD,
    ST_UP_FWD,
    ST_UP_REV_RD,
    ST_UP_REV_WR,
    ST_DONE
  } mf_state_t;

  // control from the sequencer into the residual datapath
  typedef struct packed {
    logic                res_rd;
    logic [AddrBits-1:0] res_rd_addr;
    logic                res_wr;
    logic [AddrBits-1:0] res_wr_addr;
    logic                wr_sub;
    logic                wr_copy;
  } mf_ctl_t;

endpackage

FILE: hw/rtl/mfbfs_resid.sv
// residual store with its shared add/subtract unit
// depends on mfbfs_pkg
module mfbfs_resid (
  input  logic                               clk,
  input  mfbfs_pkg::mf_ctl_t                 ctl,
  input  logic [mfbfs_pkg::CapBits-1:0]      cap_data,
  input  logic [mfbfs_pkg::ResBits-1:0]      bottleneck,
  output logic [mfbfs_pkg::ResBits-1:0]      rd_data
);
  import mfbfs_pkg::*;

  logic [ResBits-1:0] mem [MaxVertices*MaxVertices];
  logic [ResBits-1:0] wr_val;

  // copy passes the capacity through; otherwise one adder subtracts or adds back
  always_comb begin
    if (ctl.wr_copy) begin
      wr_val = {1'b0, cap_data};
    end else if (ctl.wr_sub) begin
      wr_val = rd_data - bottleneck;
    end else begin
      wr_val = rd_data + bottleneck;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_wr) begin
      mem[ctl.res_wr_addr] <= wr_val;
    end
    if (ctl.res_rd) begin
      rd_data <= mem[ctl.res_rd_addr];
    end
  end
endmodule

FILE: hw/rtl/max_flow_bfs_augmenting.sv
// max flow engine (edmonds-karp) over a 64-vertex dense graph; needs mfbfs_pkg
// load beat: one capacity write. run beat: a copy of all 4096 capacity entries into the
// residual store, then per round a bfs plus a bottleneck walk and an update walk over
// the path; at most one residual read a cycle; busy stays high for the whole run;
// out_valid pulses one cycle with the total; rst_n synchronously clears control, then a
// clearing pass of 4096 capacity entries runs with busy high; the receiver cannot stall
module max_flow_bfs_augmenting (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_kind,
  input  logic [6:0]                    in_from_vertex,
  input  logic [6:0]                    in_to_vertex,
  input  logic [30:0]                   in_capacity,
  input  logic                          cfg_we,
  input  logic [6:0]                    cfg_wdata,
  output logic                          out_valid,
  output logic [63:0]                   out_max_flow
);
  import mfbfs_pkg::*;

  mf_state_t state_r, state_nxt;
  mf_ctl_t   ctl;

  logic [CntBits-1:0]  vcount_r;
  logic [VtxBits-1:0]  sink;
  logic [AddrBits-1:0] sweep_r, sweep_nxt;
  logic                clr_done_r;
  logic [CapBits-1:0]  cap_mem [MaxVertices*MaxVertices];
  logic [CapBits-1:0]  cap_rd_r;
  logic [ResBits-1:0]  res_rd;
  logic [MaxVertices-1:0] visited_r, visited_nxt;
  logic [VtxBits-1:0]  parent_r [MaxVertices];
  logic [VtxBits-1:0]  queue_r [MaxVertices];
  logic [IdxBits-1:0]  head_r, head_nxt, tail_r, tail_nxt;
  logic [VtxBits-1:0]  u_r, u_nxt;
  logic [IdxBits-1:0]  v_r, v_nxt;
  logic [VtxBits-1:0]  w_r, w_nxt;
  logic [ResBits-1:0]  bn_r, bn_nxt;
  logic [FlowBits-1:0] flow_r, flow_nxt;
  logic                load_ok;
  logic [VtxBits-1:0]  v_idx;
  logic [VtxBits-1:0]  pw_r;
  logic [VtxBits-1:0]  qh_r;

  // clamp the vertex count to 1..64
  always_comb begin
    if (vcount_r == '0) begin
      sink = '0;
    end else if (vcount_r > CntBits'(MaxVertices)) begin
      sink = VtxBits'(MaxVertices - 1);
    end else begin
      sink = VtxBits'(vcount_r - 1'b1);
    end
  end

  assign v_idx   = v_r[VtxBits-1:0];
  assign load_ok = (in_from_vertex >= 7'd1) && (in_from_vertex <= 7'(MaxVertices))
                && (in_to_vertex >= 7'd1) && (in_to_vertex <= 7'(MaxVertices));
  assign busy    = !clr_done_r || (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 7'd2;
    end else if (cfg_we) begin
      vcount_r <= cfg_wdata;
    end
  end

  // capacity store: clearing pass, loads, and copy reads
  always_ff @(posedge clk) begin
    if (!clr_done_r) begin
      cap_mem[sweep_r[AddrBits-1:0]] <= '0;
    end else if (start && !busy && in_kind == KindLoad && load_ok) begin
      cap_mem[{in_from_vertex[VtxBits-1:0] - 1'b1, in_to_vertex[VtxBits-1:0] - 1'b1}]
        <= in_capacity;
    end
    cap_rd_r <= cap_mem[sweep_r[AddrBits-1:0]];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:      if (clr_done_r && start && in_kind == KindRun) state_nxt = ST_COPY_RD;
      ST_COPY_RD:   state_nxt = ST_COPY_WR;
      ST_COPY_WR:   state_nxt = (sweep_r[AddrBits-1:0] == '1)
                              ? ((sink == '0) ? ST_DONE : ST_BFS_INIT) : ST_COPY_RD;
      ST_BFS_INIT:  state_nxt = ST_BFS_POP;
      ST_BFS_POP:   state_nxt = (head_r < tail_r) ? ST_BFS_SCAN
                              : (visited_r[sink] ? ST_BN_RD : ST_DONE);
      ST_BFS_SCAN:  state_nxt = (v_r > IdxBits'(sink)) ? ST_BFS_POP : ST_BFS_CHECK;
      ST_BFS_CHECK: state_nxt = ST_BFS_SCAN;
      ST_BN_RD:     state_nxt = ST_BN_CMP;
      ST_BN_CMP:    state_nxt = (pw_r == '0) ? ST_UP_FWD_RD : ST_BN_RD;
      ST_UP_FWD_RD: state_nxt = ST_UP_FWD;
      ST_UP_FWD:    state_nxt = ST_UP_REV_RD;
      ST_UP_REV_RD: state_nxt = ST_UP_REV_WR;
      ST_UP_REV_WR: state_nxt = (pw_r == '0) ? ST_BFS_INIT : ST_UP_FWD_RD;
      ST_DONE:      state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl         = '0;
    sweep_nxt   = sweep_r;
    visited_nxt = visited_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    u_nxt       = u_r;
    v_nxt       = v_r;
    w_nxt       = w_r;
    bn_nxt      = bn_r;
    flow_nxt    = flow_r;
    case (state_r)
      ST_IDLE: begin
        if (!clr_done_r) begin
          sweep_nxt = sweep_r + 1'b1;
        end else begin
          sweep_nxt = '0;
        end
        flow_nxt = '0;
      end
      ST_COPY_RD: ;
      ST_COPY_WR: begin
        ctl.res_wr      = 1'b1;
        ctl.wr_copy     = 1'b1;
        ctl.res_wr_addr = sweep_r[AddrBits-1:0];
        sweep_nxt       = sweep_r + 1'b1;
      end
      ST_BFS_INIT: begin
        visited_nxt    = '0;
        visited_nxt[0] = 1'b1;
        head_nxt       = '0;
        tail_nxt       = IdxBits'(1);
      end
      ST_BFS_POP: begin
        // the source sits at the queue head on the first pop
        u_nxt    = (head_r == '0) ? '0 : qh_r;
        head_nxt = head_r + 1'b1;
        v_nxt    = '0;
      end
      ST_BFS_SCAN: begin
        ctl.res_rd      = 1'b1;
        ctl.res_rd_addr = {u_r, v_idx};
      end
      ST_BFS_CHECK: begin
        if (!visited_r[v_idx] && res_rd != '0) begin
          visited_nxt[v_idx] = 1'b1;
          if (tail_r < IdxBits'(MaxVertices)) tail_nxt = tail_r + 1'b1;
        end
        v_nxt = v_r + 1'b1;
        w_nxt = sink;
        bn_nxt = '1;
      end
      ST_BN_RD: begin
        ctl.res_rd      = 1'b1;
        ctl.res_rd_addr = {pw_r, w_r};
      end
      ST_BN_CMP: begin
        if (res_rd < bn_r) bn_nxt = res_rd;
        w_nxt = (pw_r == '0) ? sink : pw_r;
      end
      ST_UP_FWD_RD: begin
        ctl.res_rd      = 1'b1;
        ctl.res_rd_addr = {pw_r, w_r};
      end
      ST_UP_FWD: begin
        ctl.res_wr      = 1'b1;
        ctl.wr_sub      = 1'b1;
        ctl.res_wr_addr = {pw_r, w_r};
      end
      ST_UP_REV_RD: begin
        ctl.res_rd      = 1'b1;
        ctl.res_rd_addr = {w_r, pw_r};
      end
      ST_UP_REV_WR: begin
        ctl.res_wr      = 1'b1;
        ctl.res_wr_addr = {w_r, pw_r};
        if (pw_r == '0) begin
          flow_nxt = flow_r + FlowBits'(bn_r);
        end else begin
          w_nxt = pw_r;
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sweep_r    <= '0;
      clr_done_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      sweep_r   <= sweep_nxt;
      out_valid <= (state_r == ST_DONE);
      if (!clr_done_r && sweep_r[AddrBits-1:0] == '1) clr_done_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    visited_r <= visited_nxt;
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    u_r       <= u_nxt;
    v_r       <= v_nxt;
    w_r       <= w_nxt;
    bn_r      <= bn_nxt;
    flow_r    <= flow_nxt;
    // registered reads of the parent and queue arrays
    pw_r      <= parent_r[w_nxt];
    qh_r      <= queue_r[head_nxt[VtxBits-1:0]];
    if (state_r == ST_DONE) out_max_flow <= flow_r;
    if (state_r == ST_BFS_INIT) begin
      queue_r[0] <= '0;
    end
    if (state_r == ST_BFS_CHECK && !visited_r[v_idx] && res_rd != '0) begin
      parent_r[v_idx] <= u_r;
      if (tail_r < IdxBits'(MaxVertices)) queue_r[tail_r[VtxBits-1:0]] <= v_idx;
    end
  end

  mfbfs_resid u_resid (
    .clk        (clk),
    .ctl        (ctl),
    .cap_data   (cap_rd_r),
    .bottleneck (bn_r),
    .rd_data    (res_rd)
  );

  property p_strobe_after_done;
    @(posedge clk) disable iff (!rst_n)
      out_valid |-> ($past(state_r) == ST_DONE);
  endproperty
  a_strobe_after_done: assert property (p_strobe_after_done)
    else $error("result strobe without a finished run");

  property p_busy_run;
    @(posedge clk) disable iff (!rst_n)
      (state_r != ST_IDLE) |-> busy;
  endproperty
  a_busy_run: assert property (p_busy_run) else $error("idle flag during run");

  property p_single_pulse;
    @(posedge clk) disable iff (!rst_n)
      out_valid |=> !out_valid;
  endproperty
  a_single_pulse: assert property (p_single_pulse) else $error("result held two cycles");

  property p_tail_bound;
    @(posedge clk) disable iff (!rst_n)
      (state_r == ST_BFS_SCAN) |-> (tail_r <= IdxBits'(MaxVertices));
  endproperty
  a_tail_bound: assert property (p_tail_bound) else $error("queue overrun");
endmodule
